// File: sv/tmi_pkg.sv
// ----------------------------------------------------------------------------
// tmi_pkg
// Shared types and constants of the template morph interpolator: register
// indexes, mode and status codes, and the request/response of the shared
// multiply/divide unit.
// ----------------------------------------------------------------------------
package tmi_pkg;

	localparam int WORD_WIDTH_DEF = 32;
	localparam int MAX_REFS_DEF   = 6;
	localparam int REF_REGS       = 6;
	localparam int NUM_TEMPLATES  = 6;
	localparam int NUM_REGS       = 8;

	localparam int WIDE_W    = 128;
	localparam int WGT_W     = 64;
	localparam int MUL_STEPS = 64;
	localparam int DIV_STEPS = 128;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [WGT_W-1:0] WEIGHT_ONE = 64'h0000_0001_0000_0000;
	localparam logic [WGT_W-1:0] INT64_MAX  = 64'h7fff_ffff_ffff_ffff;

	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_COUNT = 3'd1;
	localparam logic [2:0] REG_REF0  = 3'd2;

	localparam logic [1:0] MODE_POLY    = 2'd0;
	localparam logic [1:0] MODE_LIN     = 2'd1;
	localparam logic [1:0] MODE_LINFRAC = 2'd2;
	localparam logic [1:0] MODE_CLIP    = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SAT   = 2'd1;
	localparam logic [1:0] ST_DEGEN = 2'd2;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} arith_op_t;

	typedef struct packed {
		logic              start;
		arith_op_t         op;
		logic [WIDE_W-1:0] opa;
		logic [WIDE_W-1:0] opb;
		logic [WIDE_W-1:0] addend;
	} arith_req_t;

	typedef struct packed {
		logic              done;
		logic [WIDE_W-1:0] result;
	} arith_rsp_t;

endpackage

// File: sv/tmi_in_if.sv
// ----------------------------------------------------------------------------
// tmi_in_if
// Request channel: target position and the template values.
// ----------------------------------------------------------------------------
interface tmi_in_if
	import tmi_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [WORD_WIDTH-1:0] target_position;
	logic signed [WORD_WIDTH-1:0] template_value_0;
	logic signed [WORD_WIDTH-1:0] template_value_1;
	logic signed [WORD_WIDTH-1:0] template_value_2;
	logic signed [WORD_WIDTH-1:0] template_value_3;
	logic signed [WORD_WIDTH-1:0] template_value_4;
	logic signed [WORD_WIDTH-1:0] template_value_5;

	modport source (
		output valid, target_position, template_value_0, template_value_1,
		       template_value_2, template_value_3, template_value_4, template_value_5,
		input  ready
	);
	modport sink (
		input  valid, target_position, template_value_0, template_value_1,
		       template_value_2, template_value_3, template_value_4, template_value_5,
		output ready
	);
endinterface

// File: sv/tmi_out_if.sv
// ----------------------------------------------------------------------------
// tmi_out_if
// Result channel: morphed value and status.
// ----------------------------------------------------------------------------
interface tmi_out_if
	import tmi_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [WORD_WIDTH-1:0] morphed_value;
	logic [1:0]                   status;

	modport source (output valid, morphed_value, status, input ready);
	modport sink (input valid, morphed_value, status, output ready);
endinterface

// File: sv/tmi_arith.sv
// ----------------------------------------------------------------------------
// tmi_arith
// Shared unsigned arithmetic unit: shift-add multiply (with an initial
// addend) and restoring divide, one adder for both.
// ----------------------------------------------------------------------------
module tmi_arith
	import tmi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  arith_req_t req,
	output arith_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	arith_op_t         op_q;
	logic [STEP_W-1:0] cnt_q;
	logic [WIDE_W-1:0] acc_q;
	logic [WIDE_W-1:0] sh_q;
	logic [WIDE_W-1:0] den_q;
	logic [WGT_W-1:0]  mp_q;

	logic [WIDE_W-1:0] add_x;
	logic [WIDE_W-1:0] add_y;
	logic              add_sub;
	logic [WIDE_W:0]   add_s;

	// multiply: acc + multiplicand, divide: shifted remainder - divisor
	always_comb begin
		if (op_q == OP_DIV) begin
			add_x   = {acc_q[WIDE_W-2:0], sh_q[WIDE_W-1]};
			add_y   = ~den_q;
			add_sub = 1'b1;
		end else begin
			add_x   = acc_q;
			add_y   = sh_q;
			add_sub = 1'b0;
		end
		add_s = {1'b0, add_x} + {1'b0, add_y} + (WIDE_W+1)'(add_sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == OP_MUL) ? STEP_W'(MUL_STEPS - 1) : STEP_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= (req.op == OP_MUL) ? req.addend : '0;
			sh_q  <= req.opa;
			mp_q  <= req.opb[WGT_W-1:0];
			den_q <= req.opb;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				if (mp_q[0]) begin
					acc_q <= add_s[WIDE_W-1:0];
				end
				sh_q <= {sh_q[WIDE_W-2:0], 1'b0};
				mp_q <= {1'b0, mp_q[WGT_W-1:1]};
			end else begin
				acc_q <= add_s[WIDE_W] ? add_s[WIDE_W-1:0] : add_x;
				sh_q  <= {sh_q[WIDE_W-2:0], add_s[WIDE_W]};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == OP_MUL) ? acc_q : sh_q;

endmodule

// File: sv/template_morph_interpolator.sv
// ----------------------------------------------------------------------------
// template_morph_interpolator
// Weighted sum of up to six template values, the weights taken from the
// configured reference positions (Lagrange, linear or clipped Lagrange).
// ----------------------------------------------------------------------------
// Usage
//   in_ch carries a request: target_position and template_value_0..5 (Q16.16).
//   out_ch returns one result per request: morphed_value and status.
//   The APB port sets morph_mode, reference_count and ref_position_0..5;
//   write it only while no request is in flight.
// Sequencing
//   All work runs through one shared multiply/divide unit. Polynomial
//   modes: n*(n-1) scale steps, each a multiply and a divide; the clipped
//   mode adds n normalize steps. Linear modes: a scan of the n references
//   plus at most one scale step. The final sum adds one multiply per
//   reference. Equal references skip the arithmetic and return a
//   degenerate status.
//   One request at a time; in_ch.ready is high only while the block is idle.
// Reset
//   morph_mode 0, reference_count 6, ref_position_k = k * 1.0.
// Stall
//   The result sits in an output register until taken; the next request is
//   accepted meanwhile, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module template_morph_interpolator
	import tmi_pkg::*;
#(
	parameter int  WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int  MAX_REFS   = MAX_REFS_DEF,
	localparam int DATA_W     = (WORD_WIDTH > 32) ? 64 : 32,
	localparam int RB_SH      = $clog2(DATA_W / 8),
	localparam int ADDR_W     = $clog2(NUM_REGS) + RB_SH
) (
	input  logic              clk,
	input  logic              arst_n,
	tmi_in_if.sink            in_ch,
	tmi_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
	localparam int CW = $clog2(MAX_REFS + 1);
	localparam int DW = WORD_WIDTH + 1;
	localparam int SUM_W = WGT_W + 3;
	localparam logic [2:0] N_MAX3 = 3'(MAX_REFS);

	typedef enum logic [16:0] {
		ST_IDLE  = 17'h00001,
		ST_CHECK = 17'h00002,
		ST_SCAN  = 17'h00004,
		ST_LSET  = 17'h00008,
		ST_PNEXT = 17'h00010,
		ST_PRI   = 17'h00020,
		ST_SMUL  = 17'h00040,
		ST_SDIV  = 17'h00080,
		ST_LW1   = 17'h00100,
		ST_LW2   = 17'h00200,
		ST_CSUM  = 17'h00400,
		ST_NMUL  = 17'h00800,
		ST_NDIV  = 17'h01000,
		ST_AMUL  = 17'h02000,
		ST_RABS  = 17'h04000,
		ST_RND   = 17'h08000,
		ST_DONE  = 17'h10000
	} state_t;

	function automatic logic signed [DW-1:0] ext(input logic signed [WORD_WIDTH-1:0] a);
		return {a[WORD_WIDTH-1], a};
	endfunction

	// configuration
	logic [1:0]                   cfg_mode_q;
	logic [2:0]                   cfg_count_q;
	logic signed [WORD_WIDTH-1:0] ref_q [REF_REGS];
	logic [2:0]                   reg_idx;
	logic [2:0]                   ref_sel;

	// sequencer
	state_t                       state_q;
	logic                         launched_q;
	logic [1:0]                   mode_q;
	logic [CW-1:0]                n_q;
	logic [CW-1:0]                pi_q;
	logic [CW-1:0]                pj_q;
	logic [CW-1:0]                imin_q;
	logic [CW-1:0]                imax_q;
	logic                         fmin_q;
	logic                         fmax_q;
	logic signed [WORD_WIDTH-1:0] x_q;
	logic signed [WORD_WIDTH-1:0] rj_q;
	logic signed [WORD_WIDTH-1:0] rmin_q;
	logic signed [WORD_WIDTH-1:0] rmax_q;
	logic signed [WORD_WIDTH-1:0] v_q [MAX_REFS];
	logic signed [WGT_W-1:0]      w_q [MAX_REFS];
	logic signed [WGT_W-1:0]      sw_q;
	logic signed [DW-1:0]         sa_q;
	logic signed [DW-1:0]         sb_q;
	logic [SUM_W-1:0]             sum_q;
	logic [WIDE_W-1:0]            acc_q;
	logic                         neg_q;
	logic                         sat_q;
	logic signed [WORD_WIDTH-1:0] res_val_q;
	logic [1:0]                   res_st_q;
	logic                         out_valid_q;
	logic signed [WORD_WIDTH-1:0] out_val_q;
	logic [1:0]                   out_st_q;

	// datapath
	logic signed [WORD_WIDTH-1:0] in_vals [NUM_TEMPLATES];
	logic [2:0]                   cnt_clamp;
	logic [CW-1:0]                rd_idx;
	logic signed [WORD_WIDTH-1:0] ref_rd;
	logic signed [WGT_W-1:0]      w_rd;
	logic signed [WORD_WIDTH-1:0] v_rd;
	logic [WGT_W-1:0]             w_mag;
	logic [WORD_WIDTH-1:0]        v_mag;
	logic [WGT_W-1:0]             sw_mag;
	logic [DW-1:0]                sa_mag;
	logic [DW-1:0]                sb_mag;
	logic                         last_i;
	logic                         bad;
	logic                         step_sat;
	logic                         step_neg;
	logic [WGT_W-1:0]             step_mag;
	logic [WGT_W-1:0]             step_res;
	logic signed [WGT_W:0]        om;
	logic                         om_sat;
	logic [WGT_W-1:0]             w_clip;
	logic [SUM_W-1:0]             sum_nx;
	logic                         le;
	logic                         ge;
	logic [WIDE_W:0]              rnd;
	logic [WIDE_W-32:0]           mag2;
	logic [WIDE_W-32:0]           lim;
	logic [WIDE_W-32:0]           mag_sel;
	logic                         rnd_sat;
	logic signed [WORD_WIDTH-1:0] rnd_res;
	arith_req_t                   areq;
	arith_rsp_t                   arsp;

	tmi_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.rsp    (arsp)
	);

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:RB_SH];
	assign ref_sel = reg_idx - REG_REF0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode_q  <= MODE_POLY;
			cfg_count_q <= 3'd6;
			for (int k = 0; k < REF_REGS; k++) begin
				ref_q[k] <= WORD_WIDTH'(k * 65536);
			end
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_MODE:  cfg_mode_q  <= pwdata[1:0];
				REG_COUNT: cfg_count_q <= pwdata[2:0];
				default:   ref_q[ref_sel] <= pwdata[WORD_WIDTH-1:0];
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:  prdata = DATA_W'(cfg_mode_q);
			REG_COUNT: prdata = DATA_W'(cfg_count_q);
			default:   prdata = DATA_W'(unsigned'(ref_q[ref_sel]));
		endcase
	end

	// ---------------- datapath ----------------
	assign in_vals[0] = in_ch.template_value_0;
	assign in_vals[1] = in_ch.template_value_1;
	assign in_vals[2] = in_ch.template_value_2;
	assign in_vals[3] = in_ch.template_value_3;
	assign in_vals[4] = in_ch.template_value_4;
	assign in_vals[5] = in_ch.template_value_5;

	assign cnt_clamp = (cfg_count_q < 3'd2) ? 3'd2 :
	                   ((cfg_count_q > N_MAX3) ? N_MAX3 : cfg_count_q);

	assign rd_idx = (state_q == ST_PRI) ? pi_q : pj_q;
	assign ref_rd = ref_q[rd_idx[AW-1:0]];
	assign w_rd   = w_q[pi_q[AW-1:0]];
	assign v_rd   = v_q[pi_q[AW-1:0]];
	assign w_mag  = w_rd[WGT_W-1] ? -w_rd : w_rd;
	assign v_mag  = v_rd[WORD_WIDTH-1] ? -v_rd : v_rd;
	assign sw_mag = sw_q[WGT_W-1] ? -sw_q : sw_q;
	assign sa_mag = sa_q[DW-1] ? -sa_q : sa_q;
	assign sb_mag = sb_q[DW-1] ? -sb_q : sb_q;
	assign last_i = (pi_q == n_q - CW'(1));

	// equal references among the used ones
	always_comb begin
		bad = 1'b0;
		for (int p = 0; p < MAX_REFS; p++) begin
			for (int q = p + 1; q < MAX_REFS; q++) begin
				if ((CW'(q) < n_q) && (ref_q[p] == ref_q[q])) begin
					bad = 1'b1;
				end
			end
		end
	end

	// scale step: w * a / b, rounded, saturated
	assign step_sat = |arsp.result[WIDE_W-1:WGT_W-1];
	assign step_mag = step_sat ? INT64_MAX : arsp.result[WGT_W-1:0];
	assign step_neg = sw_q[WGT_W-1] ^ sa_q[DW-1] ^ sb_q[DW-1];
	assign step_res = step_neg ? -step_mag : step_mag;

	assign om     = $signed({1'b0, WEIGHT_ONE}) - $signed({sw_q[WGT_W-1], sw_q});
	assign om_sat = om > $signed({1'b0, INT64_MAX});

	assign w_clip = w_rd[WGT_W-1] ? '0 : w_rd;
	assign sum_nx = sum_q + SUM_W'(w_clip);

	assign le = ref_rd <= x_q;
	assign ge = ref_rd >= x_q;

	// final rounding to Q.16 and saturation
	always_comb begin
		rnd     = {1'b0, acc_q} + ((WIDE_W+1)'(1) << 31);
		mag2    = rnd[WIDE_W:32];
		lim     = (WIDE_W-31)'(1) << (WORD_WIDTH - 1);
		rnd_sat = neg_q ? (mag2 > lim) : (mag2 > lim - (WIDE_W-31)'(1));
		mag_sel = rnd_sat ? (neg_q ? lim : lim - (WIDE_W-31)'(1)) : mag2;
		rnd_res = neg_q ? -mag_sel[WORD_WIDTH-1:0] : mag_sel[WORD_WIDTH-1:0];
	end

	// shared unit requests
	always_comb begin
		areq.start  = 1'b0;
		areq.op     = OP_MUL;
		areq.opa    = '0;
		areq.opb    = '0;
		areq.addend = '0;
		case (state_q)
			ST_SMUL: begin
				areq.start  = !launched_q;
				areq.opa    = WIDE_W'(sw_mag);
				areq.opb    = WIDE_W'(sa_mag);
				areq.addend = WIDE_W'(sb_mag >> 1);
			end
			ST_SDIV: begin
				areq.start = !launched_q;
				areq.op    = OP_DIV;
				areq.opa   = arsp.result;
				areq.opb   = WIDE_W'(sb_mag);
			end
			ST_NMUL: begin
				areq.start  = !launched_q;
				areq.opa    = WIDE_W'(w_rd);
				areq.opb    = WIDE_W'(WEIGHT_ONE);
				areq.addend = WIDE_W'(sum_q >> 1);
			end
			ST_NDIV: begin
				areq.start = !launched_q;
				areq.op    = OP_DIV;
				areq.opa   = arsp.result;
				areq.opb   = WIDE_W'(sum_q);
			end
			ST_AMUL: begin
				areq.start = !launched_q;
				areq.opa   = WIDE_W'(w_mag);
				areq.opb   = WIDE_W'(v_mag);
			end
			default: begin
				areq.start = 1'b0;
			end
		endcase
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launched_q  <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_POLY;
			n_q         <= '0;
			pi_q        <= '0;
			pj_q        <= '0;
			imin_q      <= '0;
			imax_q      <= '0;
			fmin_q      <= 1'b0;
			fmax_q      <= 1'b0;
			sat_q       <= 1'b0;
			neg_q       <= 1'b0;
			x_q         <= '0;
			rj_q        <= '0;
			rmin_q      <= '0;
			rmax_q      <= '0;
			sw_q        <= '0;
			sa_q        <= '0;
			sb_q        <= '0;
			sum_q       <= '0;
			acc_q       <= '0;
			res_val_q   <= '0;
			res_st_q    <= ST_OK;
			out_val_q   <= '0;
			out_st_q    <= ST_OK;
			for (int k = 0; k < MAX_REFS; k++) begin
				v_q[k] <= '0;
				w_q[k] <= '0;
			end
		end else begin
			if (areq.start) begin
				launched_q <= 1'b1;
			end else if (arsp.done) begin
				launched_q <= 1'b0;
			end
			if (out_ch.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						x_q    <= in_ch.target_position;
						mode_q <= cfg_mode_q;
						n_q    <= CW'(cnt_clamp);
						sat_q  <= 1'b0;
						for (int k = 0; k < MAX_REFS; k++) begin
							v_q[k] <= in_vals[k];
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					for (int k = 0; k < MAX_REFS; k++) begin
						w_q[k] <= '0;
					end
					pi_q   <= '0;
					pj_q   <= '0;
					fmax_q <= 1'b0;
					sw_q   <= WEIGHT_ONE;
					if (bad) begin
						res_val_q <= '0;
						res_st_q  <= ST_DEGEN;
						state_q   <= ST_DONE;
					end else if (mode_q inside {MODE_LIN, MODE_LINFRAC}) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_PNEXT;
					end
				end
				ST_SCAN: begin
					if (pj_q == '0) begin
						imin_q <= '0;
						rmin_q <= ref_rd;
						fmin_q <= le;
					end else if (le && (!fmin_q || ref_rd > rmin_q)) begin
						imin_q <= pj_q;
						rmin_q <= ref_rd;
						fmin_q <= 1'b1;
					end
					if ((ge && (!fmax_q || ref_rd < rmax_q)) ||
					    ((pj_q == n_q - CW'(1)) && !fmax_q)) begin
						imax_q <= pj_q;
						rmax_q <= ref_rd;
						fmax_q <= 1'b1;
					end
					if (pj_q == n_q - CW'(1)) begin
						state_q <= ST_LSET;
					end else begin
						pj_q <= pj_q + CW'(1);
					end
				end
				ST_LSET: begin
					if (imin_q == imax_q) begin
						w_q[imin_q[AW-1:0]] <= WEIGHT_ONE;
						pi_q    <= '0;
						acc_q   <= '0;
						state_q <= ST_AMUL;
					end else begin
						sw_q    <= WEIGHT_ONE;
						sa_q    <= ext(x_q) - ext(rmin_q);
						sb_q    <= ext(rmax_q) - ext(rmin_q);
						state_q <= ST_SMUL;
					end
				end
				ST_PNEXT: begin
					if (pj_q == n_q) begin
						w_q[pi_q[AW-1:0]] <= sw_q;
						if (last_i) begin
							pi_q  <= '0;
							acc_q <= '0;
							sum_q <= '0;
							state_q <= (mode_q == MODE_CLIP) ? ST_CSUM : ST_AMUL;
						end else begin
							pi_q <= pi_q + CW'(1);
							pj_q <= '0;
							sw_q <= WEIGHT_ONE;
						end
					end else if (pj_q == pi_q) begin
						pj_q <= pj_q + CW'(1);
					end else begin
						sa_q    <= ext(x_q) - ext(ref_rd);
						rj_q    <= ref_rd;
						state_q <= ST_PRI;
					end
				end
				ST_PRI: begin
					sb_q    <= ext(ref_rd) - ext(rj_q);
					state_q <= ST_SMUL;
				end
				ST_SMUL: begin
					if (arsp.done) begin
						state_q <= ST_SDIV;
					end
				end
				ST_SDIV: begin
					if (arsp.done) begin
						sw_q  <= step_res;
						sat_q <= sat_q | step_sat;
						if (mode_q inside {MODE_LIN, MODE_LINFRAC}) begin
							state_q <= ST_LW1;
						end else begin
							pj_q    <= pj_q + CW'(1);
							state_q <= ST_PNEXT;
						end
					end
				end
				ST_LW1: begin
					w_q[imax_q[AW-1:0]] <= sw_q;
					state_q <= ST_LW2;
				end
				ST_LW2: begin
					w_q[imin_q[AW-1:0]] <= om_sat ? INT64_MAX : om[WGT_W-1:0];
					sat_q   <= sat_q | om_sat;
					pi_q    <= '0;
					acc_q   <= '0;
					state_q <= ST_AMUL;
				end
				ST_CSUM: begin
					w_q[pi_q[AW-1:0]] <= w_clip;
					sum_q <= sum_nx;
					if (last_i) begin
						pi_q <= '0;
						if (sum_nx == '0) begin
							res_val_q <= '0;
							res_st_q  <= ST_DEGEN;
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_NMUL;
						end
					end else begin
						pi_q <= pi_q + CW'(1);
					end
				end
				ST_NMUL: begin
					if (arsp.done) begin
						state_q <= ST_NDIV;
					end
				end
				ST_NDIV: begin
					if (arsp.done) begin
						w_q[pi_q[AW-1:0]] <= arsp.result[WGT_W-1:0];
						if (last_i) begin
							pi_q    <= '0;
							acc_q   <= '0;
							state_q <= ST_AMUL;
						end else begin
							pi_q    <= pi_q + CW'(1);
							state_q <= ST_NMUL;
						end
					end
				end
				ST_AMUL: begin
					if (arsp.done) begin
						if (w_rd[WGT_W-1] != v_rd[WORD_WIDTH-1]) begin
							acc_q <= acc_q - arsp.result;
						end else begin
							acc_q <= acc_q + arsp.result;
						end
						if (last_i) begin
							state_q <= ST_RABS;
						end else begin
							pi_q <= pi_q + CW'(1);
						end
					end
				end
				ST_RABS: begin
					neg_q   <= acc_q[WIDE_W-1];
					acc_q   <= acc_q[WIDE_W-1] ? -acc_q : acc_q;
					state_q <= ST_RND;
				end
				ST_RND: begin
					res_val_q <= rnd_res;
					res_st_q  <= (sat_q || rnd_sat) ? ST_SAT : ST_OK;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_val_q   <= res_val_q;
						out_st_q    <= res_st_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready          = (state_q == ST_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.morphed_value = out_val_q;
	assign out_ch.status        = out_st_q;

endmodule

// File: sv/tmi_checker.sv
// ----------------------------------------------------------------------------
// tmi_checker
// Port-level assertions for the template morph interpolator, bound to the
// top level.
// ----------------------------------------------------------------------------
module tmi_checker
	import tmi_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [WORD_WIDTH-1:0] morphed_value,
	input logic [1:0]            status
);

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(morphed_value) && $stable(status))
		else $error("result changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// degenerate result carries zero
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DEGEN |-> morphed_value == '0)
		else $error("degenerate result not zero");

endmodule

bind template_morph_interpolator tmi_checker #(.WORD_WIDTH(WORD_WIDTH)) u_tmi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.morphed_value (out_ch.morphed_value),
	.status        (out_ch.status)
);
